// ===== hdl/fbs_pkg.sv =====
// Package for the float32 binary scale block: field widths, beat types and helpers.
// Depends on nothing; the decode, plan, pack and top-level files refer to it by scoped names.
package fbs_pkg;

   localparam int XW  = 32;
   localparam int SW  = 64;
   localparam int MW  = 23;

   typedef struct packed {
      logic [31:0] x_bits;
      logic signed [63:0] scale;
   } req_type;

   typedef struct packed {
      logic [31:0] result_bits;
      logic        overflow_flag;
      logic        underflow_flag;
   } rsp_type;

   // Operand classes decided in the first stage.
   localparam logic [1:0] CLS_PASS = 2'd0;
   localparam logic [1:0] CLS_NORM = 2'd1;
   localparam logic [1:0] CLS_SUB  = 2'd2;

   // Decoded operand after the first stage. The scale is clamped to an
   // 11-bit signed value (+-1000 is beyond every boundary the logic uses).
   typedef struct packed {
      logic [1:0]         cls;
      logic               sign;
      logic [7:0]         expo;
      logic [22:0]        mant;
      logic signed [10:0] n;
      logic [4:0]         lz;
      logic [31:0]        x_bits;
   } dec_type;

   // Second stage: the shift plan.
   localparam logic [2:0] OP_PASS  = 3'd0;
   localparam logic [2:0] OP_RIGHT = 3'd1;
   localparam logic [2:0] OP_LEFT  = 3'd2;
   localparam logic [2:0] OP_INF   = 3'd3;
   localparam logic [2:0] OP_NORM  = 3'd4;
   localparam logic [2:0] OP_RENRM = 3'd5;

   typedef struct packed {
      logic [2:0]  op;
      logic        sign;
      logic [7:0]  expo;
      logic [23:0] full;
      logic [4:0]  sh;
      logic        zero;
      logic        unf;
      logic [31:0] x_bits;
   } plan_type;

   function automatic logic [4:0] lead_zeros(input logic [22:0] m);
      logic [4:0] lz;
      lz = 5'd23;
      for (int i = 0; i < 23; i++) begin
         if (m[i]) lz = 5'(22 - i);
      end
      return lz;
   endfunction

endpackage

// ===== hdl/fbs_if.sv =====
// Valid/ready channel interface carrying one beat of a given payload type.
// Depends on fbs_pkg only through the type parameter supplied at instantiation.
interface fbs_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fbs_decode.sv =====
// Stage one: classify the operand, clamp the scale, count mantissa leading zeros.
// Depends on fbs_pkg.
module fbs_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  fbs_pkg::req_type  in_data,
   output logic              out_valid,
   output fbs_pkg::dec_type  out_data
);
   logic             valid_ff, valid_in;
   fbs_pkg::dec_type data_ff, data_in;
   logic [7:0]       e;
   logic [22:0]      m;
   logic signed [63:0] s;

   always_comb begin
      e = in_data.x_bits[30:23];
      m = in_data.x_bits[22:0];
      s = in_data.scale;
      data_in.sign   = in_data.x_bits[31];
      data_in.expo   = e;
      data_in.mant   = m;
      data_in.x_bits = in_data.x_bits;
      data_in.lz     = fbs_pkg::lead_zeros(m);
      if (s > 64'sd1000)       data_in.n = 11'sd1000;
      else if (s < -64'sd1000) data_in.n = -11'sd1000;
      else                     data_in.n = s[10:0];
      if (e == 8'hFF || (e == 8'd0 && m == '0)) data_in.cls = fbs_pkg::CLS_PASS;
      else if (e != 8'd0)                       data_in.cls = fbs_pkg::CLS_NORM;
      else                                      data_in.cls = fbs_pkg::CLS_SUB;
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== hdl/fbs_plan.sv =====
// Stage two: exponent arithmetic and range checks that choose the shift.
// Depends on fbs_pkg.
module fbs_plan (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  fbs_pkg::dec_type  in_data,
   output logic              out_valid,
   output fbs_pkg::plan_type out_data
);
   logic              valid_ff;
   fbs_pkg::plan_type data_ff, data_in;
   logic signed [11:0] sum, nlz, rsh;

   always_comb begin
      sum = 12'(signed'({1'b0, in_data.expo})) + 12'(in_data.n);
      nlz = 12'(in_data.n) - 12'(signed'({1'b0, in_data.lz}));
      rsh = 12'sd1 - sum;
      data_in.sign   = in_data.sign;
      data_in.x_bits = in_data.x_bits;
      data_in.full   = {1'b1, in_data.mant};
      data_in.expo   = in_data.expo;
      data_in.sh     = '0;
      data_in.zero   = 1'b0;
      data_in.unf    = 1'b0;
      data_in.op     = fbs_pkg::OP_PASS;
      unique case (in_data.cls)
         fbs_pkg::CLS_NORM: begin
            if (sum <= 12'sd0) begin
               data_in.op   = fbs_pkg::OP_RIGHT;
               data_in.unf  = 1'b1;
               data_in.zero = (rsh >= 12'sd24);
               data_in.sh   = rsh[4:0];
            end else if (sum >= 12'sd255) begin
               data_in.op = fbs_pkg::OP_INF;
            end else begin
               data_in.op   = fbs_pkg::OP_NORM;
               data_in.expo = sum[7:0];
            end
         end
         fbs_pkg::CLS_SUB: begin
            data_in.full = {1'b0, in_data.mant};
            if (in_data.n <= 11'sd0) begin
               data_in.op   = fbs_pkg::OP_RIGHT;
               data_in.zero = (in_data.n <= -11'sd23);
               data_in.sh   = 5'(-in_data.n);
            end else if (nlz <= 12'sd0) begin
               data_in.op = fbs_pkg::OP_LEFT;
               data_in.sh = in_data.n[4:0];
            end else if (nlz >= 12'sd255) begin
               data_in.op = fbs_pkg::OP_INF;
            end else begin
               data_in.op   = fbs_pkg::OP_RENRM;
               data_in.expo = nlz[7:0];
               data_in.sh   = 5'(in_data.lz + 5'd1);
            end
         end
         default: data_in.op = fbs_pkg::OP_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== hdl/fbs_pack.sv =====
// Stage three: mantissa shift and packing of the result word and flags.
// Depends on fbs_pkg.
module fbs_pack (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  fbs_pkg::plan_type in_data,
   output logic              out_valid,
   output fbs_pkg::rsp_type  out_data
);
   logic             valid_ff;
   fbs_pkg::rsp_type data_ff, data_in;
   logic [23:0]      rsh;
   logic [22:0]      lsh;

   always_comb begin
      rsh = in_data.zero ? 24'd0 : (in_data.full >> in_data.sh);
      lsh = in_data.full[22:0] << in_data.sh;
      data_in.overflow_flag  = 1'b0;
      data_in.underflow_flag = in_data.unf;
      unique case (in_data.op)
         fbs_pkg::OP_RIGHT: data_in.result_bits = {in_data.sign, 8'd0, rsh[22:0]};
         fbs_pkg::OP_LEFT:  data_in.result_bits = {in_data.sign, 8'd0, lsh};
         fbs_pkg::OP_INF: begin
            data_in.result_bits   = {in_data.sign, 8'hFF, 23'd0};
            data_in.overflow_flag = 1'b1;
         end
         fbs_pkg::OP_NORM:  data_in.result_bits =
                               {in_data.sign, in_data.expo, in_data.full[22:0]};
         fbs_pkg::OP_RENRM: data_in.result_bits = {in_data.sign, in_data.expo, lsh};
         default:           data_in.result_bits = in_data.x_bits;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== hdl/float32_binary_scale.sv =====
// Top level of the float32 binary scale block: three-stage pipeline with handshake.
// Depends on fbs_pkg, fbs_if, fbs_decode, fbs_plan and fbs_pack.
//
// This block multiplies a single-precision bit pattern by a signed 64-bit power
// of two, truncating rather than rounding, and reports overflow (saturation to
// a signed infinity) and underflow (a normal operand that became denormal or
// zero). Zero, infinity and NaN pass through unchanged. Every request beat
// yields exactly one response beat, and a new beat is taken in every cycle
// in which the pipeline advances. Each beat passes through the three register
// stages (decode with leading-zero count, exponent arithmetic, mantissa shift
// and pack). The whole pipeline advances together whenever the output register
// is empty or is being drained, so a stalled response holds every stage in
// place and no beat is lost or repeated. There is no configuration and no
// state beyond the pipeline itself; reset clears only the valid bits.
module float32_binary_scale (
   input logic  clock,
   input logic  reset,
   fbs_if.sink   req,
   fbs_if.source rsp
);
   logic              adv;
   logic              v1, v2;
   fbs_pkg::dec_type  d1;
   fbs_pkg::plan_type d2;

   // Advance all stages when the last stage is empty or its beat is taken.
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   fbs_decode u_decode (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req.valid), .in_data(req.data),
      .out_valid(v1), .out_data(d1)
   );

   fbs_plan u_plan (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v1), .in_data(d1),
      .out_valid(v2), .out_data(d2)
   );

   fbs_pack u_pack (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v2), .in_data(d2),
      .out_valid(rsp.valid), .out_data(rsp.data)
   );
endmodule
